// File: src/lca_pkg.sv
package lca_pkg;

   localparam int MAX_NODES  = 1024;
   localparam int TOUR_DEPTH = 2048;

   localparam int NODE_W = 10;
   localparam int LVL_W  = 11;
   localparam int POS_W  = $clog2(TOUR_DEPTH);
   localparam int CNT_W  = POS_W + 1;
   localparam int NADR_W = $clog2(MAX_NODES);

   // request codes
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;
   localparam logic [1:0] REQ_RSVD   = 2'd3;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [NODE_W-1:0] tour_node;
      logic [LVL_W-1:0]  tour_level;
      logic [NODE_W-1:0] node_u;
      logic [NODE_W-1:0] node_v;
   } req_item_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic              unknown_node;
   } rsp_item_type;

   // tour element and per-node entry as stored
   typedef struct packed {
      logic [NODE_W-1:0] id;
      logic [LVL_W-1:0]  depth;
   } tour_entry_type;

   typedef struct packed {
      logic             seen;
      logic [POS_W-1:0] pos;
   } node_entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_APPEND,
      ST_QRY_U,
      ST_QRY_V,
      ST_SCAN,
      ST_RESP
   } st_type;

endpackage

// File: src/euler_tour_lca_rmq.sv
// Lowest common ancestor over a stored Euler tour.
// Input channel req_*: one item per handshake; req_data.req_type selects
// clear, append (tour_node, tour_level) or query (node_u, node_v).
// Result channel rsp_*: one item per query, none for other requests.
// A clear sweeps the node table, one entry per cycle. A query scans the
// tour range lo..hi between the first positions of the two nodes; the
// tour memory is read one element per cycle and the minimum depth is
// tracked on the fly. A query of an unknown node skips the scan.
// The result sits in an output register and stays there while rsp_stall
// is high. The block then waits in its final step until the register
// drains, and keeps req_stall high. After reset the node table is swept
// with req_stall high; the tour is empty afterward.
module euler_tour_lca_rmq import lca_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   st_type            state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [NADR_W:0]   clr_ff, clr_in;
   req_item_type      item_ff, item_in;
   node_entry_type    u_ent_ff, u_ent_in;
   logic [POS_W-1:0]  cur_ff, cur_in;
   logic [POS_W-1:0]  hi_ff, hi_in;
   logic              first_ff, first_in;
   logic [LVL_W-1:0]  best_depth_ff, best_depth_in;
   logic [NODE_W-1:0] best_id_ff, best_id_in;
   logic              unk_ff, unk_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_data_ff, rsp_data_in;

   logic              node_we;
   logic [NADR_W-1:0] node_waddr, node_raddr;
   node_entry_type    node_wdata, node_rdata;
   logic              tour_we;
   logic [POS_W-1:0]  tour_waddr, tour_raddr;
   tour_entry_type    tour_wdata, tour_rdata;

   logic              accept;
   logic [POS_W-1:0]  lo_pos, hi_pos;
   logic              better;

   lca_ram #(.WIDTH(1 + POS_W), .DEPTH(MAX_NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   lca_ram #(.WIDTH(NODE_W + LVL_W), .DEPTH(TOUR_DEPTH)) u_tour_ram (
      .clock   (clock),
      .wr_en   (tour_we),
      .wr_addr (tour_waddr),
      .wr_data (tour_wdata),
      .rd_addr (tour_raddr),
      .rd_data (tour_rdata)
   );

   assign accept = req_valid && !req_stall;

   // range ends from the two first positions
   assign lo_pos = (u_ent_ff.pos < node_rdata.pos) ? u_ent_ff.pos : node_rdata.pos;
   assign hi_pos = (u_ent_ff.pos < node_rdata.pos) ? node_rdata.pos : u_ent_ff.pos;
   assign better = first_ff || (tour_rdata.depth < best_depth_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      u_ent_ff      <= u_ent_in;
      cur_ff        <= cur_in;
      hi_ff         <= hi_in;
      first_ff      <= first_in;
      best_depth_ff <= best_depth_in;
      best_id_ff    <= best_id_in;
      unk_ff        <= unk_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      item_in       = item_ff;
      u_ent_in      = u_ent_ff;
      cur_in        = cur_ff;
      hi_in         = hi_ff;
      first_in      = first_ff;
      best_depth_in = best_depth_ff;
      best_id_in    = best_id_ff;
      unk_in        = unk_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      req_stall     = (state_ff != ST_IDLE);
      node_we       = 1'b0;
      node_waddr    = item_ff.tour_node;
      node_wdata    = '{seen: 1'b1, pos: count_ff[POS_W-1:0]};
      node_raddr    = req_data.node_u;
      tour_we       = 1'b0;
      tour_waddr    = count_ff[POS_W-1:0];
      tour_wdata    = '{id: item_ff.tour_node, depth: item_ff.tour_level};
      tour_raddr    = cur_ff + POS_W'(1);

      case (state_ff)
         ST_CLEAR: begin
            node_we    = 1'b1;
            node_waddr = clr_ff[NADR_W-1:0];
            node_wdata = '{seen: 1'b0, pos: '0};
            clr_in     = clr_ff + (NADR_W+1)'(1);
            if (clr_ff[NADR_W-1:0] == NADR_W'(MAX_NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            node_raddr = (req_data.req_type == REQ_APPEND) ? req_data.tour_node
                                                           : req_data.node_u;
            if (accept) begin
               item_in = req_data;
               case (req_data.req_type)
                  REQ_CLEAR: begin
                     state_in = ST_CLEAR;
                     count_in = '0;
                     clr_in   = '0;
                  end
                  REQ_APPEND: state_in = ST_APPEND;
                  REQ_QUERY:  state_in = ST_QRY_U;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_APPEND: begin
            if (count_ff != CNT_W'(TOUR_DEPTH)) begin
               tour_we  = 1'b1;
               node_we  = !node_rdata.seen;
               count_in = count_ff + CNT_W'(1);
            end
            state_in = ST_IDLE;
         end
         ST_QRY_U: begin
            u_ent_in   = node_rdata;
            node_raddr = item_ff.node_v;
            state_in   = ST_QRY_V;
         end
         ST_QRY_V: begin
            if (!u_ent_ff.seen || !node_rdata.seen) begin
               unk_in   = 1'b1;
               state_in = ST_RESP;
            end else begin
               unk_in     = 1'b0;
               tour_raddr = lo_pos;
               cur_in     = lo_pos;
               hi_in      = hi_pos;
               first_in   = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // tour_rdata holds element cur_ff
            first_in = 1'b0;
            if (better) begin
               best_depth_in = tour_rdata.depth;
               best_id_in    = tour_rdata.id;
            end
            cur_in = cur_ff + POS_W'(1);
            if (cur_ff == hi_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = unk_ff ? rsp_item_type'{ancestor: '0, unknown_node: 1'b1}
                                     : rsp_item_type'{ancestor: best_id_ff,
                                                      unknown_node: 1'b0};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // a pending result is never dropped while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("result dropped under stall");

   // tour count stays within the memory
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TOUR_DEPTH))
      else $error("tour count overflow");

   // no item is taken during the node table sweep
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall)
      else $error("item accepted during sweep");

   // scan never runs past the range end
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cur_ff <= hi_ff)
      else $error("scan past range end");
`endif

endmodule

// File: src/lca_ram.sv
module lca_ram import lca_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: bench/euler_tour_lca_rmq_tb.sv
`timescale 1ns / 1ps

module euler_tour_lca_rmq_tb;
   import lca_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;

   euler_tour_lca_rmq u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // pending requests, expected answers
   req_item_type pending_reqs[$];
   rsp_item_type lca_expected[$];
   int           total_reqs;
   int           sent_reqs = 0;
   int           mismatches = 0;
   logic         req_taken;

   // shadow copy of the tour store
   logic [NODE_W-1:0] sh_ids [TOUR_DEPTH];
   logic [LVL_W-1:0]  sh_lvls [TOUR_DEPTH];
   int                sh_first [MAX_NODES];
   bit                sh_seen [MAX_NODES];
   int                sh_count = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // overall time limit
   initial begin
      #200ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic req_item_type make_req(logic [1:0] kind, int node, int lvl, int u,
                                             int v);
      req_item_type r;
      r.req_type   = kind;
      r.tour_node  = NODE_W'(node);
      r.tour_level = LVL_W'(lvl);
      r.node_u     = NODE_W'(u);
      r.node_v     = NODE_W'(v);
      return r;
   endfunction

   task automatic queue_req(req_item_type r);
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic push_append(int node, int lvl);
      queue_req(make_req(REQ_APPEND, node, lvl, $urandom, $urandom));
   endtask

   task automatic push_query(int u, int v);
      queue_req(make_req(REQ_QUERY, $urandom, $urandom, u, v));
   endtask

   task automatic push_clear();
      queue_req(make_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom));
   endtask

   // update the shadow store, return the expected answer for queries
   function automatic bit predict_lca(req_item_type r, output rsp_item_type a);
      int lo, hi, best;
      a = '0;
      case (r.req_type)
         REQ_CLEAR: begin
            foreach (sh_seen[i]) sh_seen[i] = 1'b0;
            sh_count = 0;
            return 1'b0;
         end
         REQ_APPEND: begin
            if (sh_count < TOUR_DEPTH) begin
               sh_ids[sh_count]  = r.tour_node;
               sh_lvls[sh_count] = r.tour_level;
               if (!sh_seen[r.tour_node]) begin
                  sh_seen[r.tour_node]  = 1'b1;
                  sh_first[r.tour_node] = sh_count;
               end
               sh_count++;
            end
            return 1'b0;
         end
         REQ_QUERY: begin
            if (!sh_seen[r.node_u] || !sh_seen[r.node_v]) begin
               a.unknown_node = 1'b1;
               return 1'b1;
            end
            lo = sh_first[r.node_u];
            hi = sh_first[r.node_v];
            if (hi < lo) begin
               best = lo; lo = hi; hi = best;
            end
            best = lo;
            for (int i = lo + 1; i <= hi && i < sh_count; i++)
               if (sh_lvls[i] < sh_lvls[best]) best = i;
            a.ancestor = sh_ids[best];
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // builds one random Euler tour of n nodes and queries over it
   task automatic push_tree(int n, int nq, ref int cnt);
      int stk[$];
      int known[$];
      int base, id, left, u, v;
      base = $urandom_range(1, 990);
      id   = $urandom_range(0, 1023);
      push_clear();
      stk   = {stk, id};
      known = {known, id};
      push_append(id, base);
      cnt += 2;
      left = n - 1;
      while (stk.size() > 1 || left > 0) begin
         if (left > 0 && (stk.size() == 1 || $urandom_range(0, 1))) begin
            id = $urandom_range(0, 1023);
            stk   = {stk, id};
            known = {known, id};
            left--;
         end else begin
            void'(stk.pop_back());
         end
         push_append(stk[$], base + stk.size() - 1);
         cnt++;
      end
      repeat (nq) begin
         u = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                         : known[$urandom_range(0, known.size() - 1)];
         v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                         : known[$urandom_range(0, known.size() - 1)];
         push_query(u, v);
         cnt++;
      end
   endtask

   // stimulus
   initial begin
      int cnt;
      cnt = 0;

      // directed: empty tour, small tree, extremes, unused code
      push_query(5, 5);
      push_append(7, 1);
      push_query(7, 7);
      push_query(7, 8);
      push_append(1023, 2);
      push_append(7, 1);
      push_append(0, 2);
      push_append(341, 3);
      push_append(0, 2);
      push_append(7, 1);
      push_append(682, 2047);
      push_append(7, 1024);
      push_query(1023, 0);
      push_query(341, 1023);
      push_query(0, 341);
      push_query(682, 341);
      push_query(1023, 1023);
      queue_req(make_req(REQ_RSVD, 1023, 2047, 1023, 1023));
      push_clear();
      push_query(7, 7);
      push_append(0, 0);
      push_query(0, 0);

      // random: mostly well-formed tours, some noise
      while (cnt < 1000) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_req(make_req(2'($urandom_range(0, 3)), $urandom, $urandom,
                               $urandom, $urandom));
            cnt++;
         end else begin
            push_tree($urandom_range(1, 30), $urandom_range(3, 10), cnt);
         end
      end
      total_reqs = pending_reqs.size();

      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_reqs.size() == 0 && !req_valid && lca_expected.size() == 0);
      repeat (1200) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // idle rates by phase: sender 28 / receiver 53, then swapped, then none
   function automatic int send_idle_pct();
      if (sent_reqs < total_reqs / 3) return 28;
      if (sent_reqs < 2 * total_reqs / 3) return 53;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (sent_reqs < total_reqs / 3) return 53;
      if (sent_reqs < 2 * total_reqs / 3) return 28;
      return 0;
   endfunction

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct());
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
               sent_reqs++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: accept and check on the rising edge
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            if (predict_lca(req_data, want)) lca_expected.push_back(want);
         if (rsp_valid && !rsp_stall) begin
            if (lca_expected.size() == 0) begin
               report_mismatch("unexpected answer, ancestor", int'(rsp_data.ancestor), -1);
            end else begin
               want = lca_expected.pop_front();
               if (rsp_data.ancestor !== want.ancestor)
                  report_mismatch("ancestor", int'(rsp_data.ancestor),
                                  int'(want.ancestor));
               if (rsp_data.unknown_node !== want.unknown_node)
                  report_mismatch("unknown_node", int'(rsp_data.unknown_node),
                                  int'(want.unknown_node));
            end
         end
      end
   end

endmodule
